### rtl/sdrm_pkg.sv
// ----------------------------------------------------------------------------
// sdrm_pkg
// Shared types and codes for the signed divider with rounding modes.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrm_pkg;

    // Operation selected by the input tuser field. Codes 5 to 7 are unused.
    typedef enum logic [2:0] {
        KIND_EUCLID_QUO = 3'd0,
        KIND_EUCLID_REM = 3'd1,
        KIND_TRUNC_QUO  = 3'd2,
        KIND_TRUNC_REM  = 3'd3,
        KIND_FLOOR_MOD  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_DIV_ZERO = 2'd1,
        ERR_OVERFLOW = 2'd2
    } err_t;

    localparam int KIND_BITS = 3;
    localparam int ERR_BITS  = 2;

    // Side information that travels down the pipeline beside the operands.
    typedef struct packed {
        kind_t kind;
        logic  neg_a;
        logic  neg_b;
        logic  div_zero;
        logic  ovf;
    } ctl_t;

endpackage

`default_nettype wire

### rtl/sdrm_div_step.sv
// ----------------------------------------------------------------------------
// sdrm_div_step
// One registered step of the restoring divider: it produces one quotient bit
// and keeps its own valid bit and handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrm_div_step #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [WORD_BITS-1:0] in_rem,
    input  wire logic [WORD_BITS-1:0] in_quo,
    input  wire logic [WORD_BITS-1:0] in_mb,
    input  wire sdrm_pkg::ctl_t       in_ctl,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [WORD_BITS-1:0]      out_rem,
    output logic [WORD_BITS-1:0]      out_quo,
    output logic [WORD_BITS-1:0]      out_mb,
    output sdrm_pkg::ctl_t            out_ctl
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] rem_next;
    logic [WORD_BITS-1:0] quo_reg;
    logic [WORD_BITS-1:0] quo_next;
    logic [WORD_BITS-1:0] mb_reg;
    sdrm_pkg::ctl_t       ctl_reg;
    logic [WORD_BITS:0]   partial;
    logic [WORD_BITS:0]   trial;
    logic                 fits;
    logic                 load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // The partial remainder is always below twice the divisor, so it fits in
    // one bit more than the word.
    always_comb
    begin
        partial  = {in_rem, in_quo[WORD_BITS-1]};
        trial    = partial - {1'b0, in_mb};
        fits     = partial >= {1'b0, in_mb};
        rem_next = fits ? trial[WORD_BITS-1:0] : partial[WORD_BITS-1:0];
        quo_next = {in_quo[WORD_BITS-2:0], fits};
    end

    always_comb
    begin
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            mb_reg  <= in_mb;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_mb    = mb_reg;
    assign out_ctl   = ctl_reg;

endmodule

`default_nettype wire

### rtl/signed_divider_rounding_modes.sv
// ----------------------------------------------------------------------------
// signed_divider_rounding_modes
// Pipelined signed divider giving Euclidean, truncating or floor results.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and
// returns results in order through registered stages: the operand stage takes
// magnitudes, WORD_BITS restoring division steps give one quotient bit each,
// the sign stage restores signs and the output stage selects the answer. Every
// stage holds its own valid bit, so a stall on the output fills empty stages
// before the input side is held. A zero divisor gives an answer of zero with
// the division-by-zero code; the most negative dividend divided by minus one
// gives the wrapped quotient with the overflow code for the quotient kinds.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_divider_rounding_modes #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: dividend, divisor, zero padding.
    input  wire logic [((2*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Fields from bit 0: kind.
    input  wire logic [sdrm_pkg::KIND_BITS-1:0]   s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // Fields from bit 0: answer, zero padding.
    output logic [((WORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // Fields from bit 0: error_code.
    output logic [sdrm_pkg::ERR_BITS-1:0]   m_axis_tuser
);

    localparam int OUT_TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
    localparam logic [WORD_BITS-1:0] WTOP = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Step chain: index 0 is the operand stage, index WORD_BITS the last step.
    logic                 step_valid [WORD_BITS+1];
    logic                 step_ready [WORD_BITS+1];
    logic [WORD_BITS-1:0] step_rem   [WORD_BITS+1];
    logic [WORD_BITS-1:0] step_quo   [WORD_BITS+1];
    logic [WORD_BITS-1:0] step_mb    [WORD_BITS+1];
    sdrm_pkg::ctl_t       step_ctl   [WORD_BITS+1];

    // Operand stage.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [WORD_BITS-1:0] in_ma_reg;
    logic [WORD_BITS-1:0] in_mb_reg;
    sdrm_pkg::ctl_t       in_ctl_reg;
    logic [WORD_BITS-1:0] in_a;
    logic [WORD_BITS-1:0] in_b;
    logic [WORD_BITS-1:0] in_ma_next;
    logic [WORD_BITS-1:0] in_mb_next;
    sdrm_pkg::ctl_t       in_ctl_next;
    logic                 in_load;

    // Sign stage.
    logic                 sg_valid_reg;
    logic                 sg_valid_next;
    logic                 sg_ready;
    logic                 sg_load;
    logic [WORD_BITS-1:0] sg_qs_reg;
    logic [WORD_BITS-1:0] sg_qs_next;
    logic [WORD_BITS-1:0] sg_r_reg;
    logic [WORD_BITS-1:0] sg_r_next;
    logic [WORD_BITS-1:0] sg_rm_reg;
    logic [WORD_BITS-1:0] sg_up_reg;
    logic [WORD_BITS-1:0] sg_up_next;
    logic [WORD_BITS-1:0] sg_dn_reg;
    logic [WORD_BITS-1:0] sg_dn_next;
    logic                 sg_rmnz_reg;
    sdrm_pkg::ctl_t       sg_ctl_reg;

    // Output stage.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_ready;
    logic                 out_load;
    logic [WORD_BITS-1:0] out_ans_reg;
    logic [WORD_BITS-1:0] out_ans_next;
    sdrm_pkg::err_t       out_err_reg;
    sdrm_pkg::err_t       out_err_next;

    // ------------------------------------------------------------------
    // Operand stage: magnitudes and special cases.
    // ------------------------------------------------------------------
    assign in_a          = s_axis_tdata[WORD_BITS-1:0];
    assign in_b          = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];
    assign s_axis_tready = !in_valid_reg || step_ready[0];
    assign in_load       = s_axis_tvalid && s_axis_tready;

    // The negated most negative value reads as its true magnitude when the
    // word is taken as unsigned.
    always_comb
    begin
        in_ma_next           = in_a[WORD_BITS-1] ? (~in_a + 1'b1) : in_a;
        in_mb_next           = in_b[WORD_BITS-1] ? (~in_b + 1'b1) : in_b;
        in_ctl_next.kind     = sdrm_pkg::kind_t'(s_axis_tuser);
        in_ctl_next.neg_a    = in_a[WORD_BITS-1];
        in_ctl_next.neg_b    = in_b[WORD_BITS-1];
        in_ctl_next.div_zero = (in_b == '0);
        in_ctl_next.ovf      = (in_a == WTOP) && (in_b == '1);
    end

    always_comb
    begin
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_ma_reg  <= in_ma_next;
            in_mb_reg  <= in_mb_next;
            in_ctl_reg <= in_ctl_next;
        end
    end

    assign step_valid[0] = in_valid_reg;
    assign step_rem[0]   = '0;
    assign step_quo[0]   = in_ma_reg;
    assign step_mb[0]    = in_mb_reg;
    assign step_ctl[0]   = in_ctl_reg;

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_step
        sdrm_div_step #(
            .WORD_BITS (WORD_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (step_valid[i]),
            .in_ready  (step_ready[i]),
            .in_rem    (step_rem[i]),
            .in_quo    (step_quo[i]),
            .in_mb     (step_mb[i]),
            .in_ctl    (step_ctl[i]),
            .out_valid (step_valid[i+1]),
            .out_ready (step_ready[i+1]),
            .out_rem   (step_rem[i+1]),
            .out_quo   (step_quo[i+1]),
            .out_mb    (step_mb[i+1]),
            .out_ctl   (step_ctl[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Sign stage: signed quotient and remainder, and the divisor-adjusted
    // remainders needed by the Euclidean and floor kinds.
    // ------------------------------------------------------------------
    assign sg_ready              = !sg_valid_reg || out_ready;
    assign step_ready[WORD_BITS] = sg_ready;
    assign sg_load               = step_valid[WORD_BITS] && sg_ready;

    always_comb
    begin
        sg_qs_next = (step_ctl[WORD_BITS].neg_a ^ step_ctl[WORD_BITS].neg_b)
                   ? (~step_quo[WORD_BITS] + 1'b1) : step_quo[WORD_BITS];
        sg_r_next  = step_ctl[WORD_BITS].neg_a
                   ? (~step_rem[WORD_BITS] + 1'b1) : step_rem[WORD_BITS];
        sg_up_next = step_mb[WORD_BITS] - step_rem[WORD_BITS];
        sg_dn_next = step_rem[WORD_BITS] - step_mb[WORD_BITS];
    end

    always_comb
    begin
        if (sg_ready)
        begin
            sg_valid_next = step_valid[WORD_BITS];
        end
        else
        begin
            sg_valid_next = sg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_valid_reg <= 1'b0;
        end
        else
        begin
            sg_valid_reg <= sg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sg_load)
        begin
            sg_qs_reg   <= sg_qs_next;
            sg_r_reg    <= sg_r_next;
            sg_rm_reg   <= step_rem[WORD_BITS];
            sg_up_reg   <= sg_up_next;
            sg_dn_reg   <= sg_dn_next;
            sg_rmnz_reg <= (step_rem[WORD_BITS] != '0);
            sg_ctl_reg  <= step_ctl[WORD_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: select the answer and the error code.
    // ------------------------------------------------------------------
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign out_load  = sg_valid_reg && out_ready;

    always_comb
    begin
        out_ans_next = '0;
        out_err_next = sdrm_pkg::ERR_NONE;
        unique case (sg_ctl_reg.kind)
            sdrm_pkg::KIND_EUCLID_QUO:
            begin
                // A negative truncated remainder moves the quotient away from
                // the divisor's sign.
                if (sg_rmnz_reg && sg_ctl_reg.neg_a)
                begin
                    out_ans_next = sg_ctl_reg.neg_b ? (sg_qs_reg + 1'b1)
                                                    : (sg_qs_reg - 1'b1);
                end
                else
                begin
                    out_ans_next = sg_qs_reg;
                end
            end
            sdrm_pkg::KIND_EUCLID_REM:
            begin
                out_ans_next = (sg_rmnz_reg && sg_ctl_reg.neg_a) ? sg_up_reg
                                                                 : sg_rm_reg;
            end
            sdrm_pkg::KIND_TRUNC_QUO:
            begin
                out_ans_next = sg_qs_reg;
            end
            sdrm_pkg::KIND_TRUNC_REM:
            begin
                out_ans_next = sg_r_reg;
            end
            sdrm_pkg::KIND_FLOOR_MOD:
            begin
                if (sg_rmnz_reg && (sg_ctl_reg.neg_a ^ sg_ctl_reg.neg_b))
                begin
                    out_ans_next = sg_ctl_reg.neg_a ? sg_up_reg : sg_dn_reg;
                end
                else
                begin
                    out_ans_next = sg_r_reg;
                end
            end
            default:
            begin
                out_ans_next = '0;
            end
        endcase

        if (sg_ctl_reg.kind == sdrm_pkg::KIND_EUCLID_QUO
            || sg_ctl_reg.kind == sdrm_pkg::KIND_EUCLID_REM
            || sg_ctl_reg.kind == sdrm_pkg::KIND_TRUNC_QUO
            || sg_ctl_reg.kind == sdrm_pkg::KIND_TRUNC_REM
            || sg_ctl_reg.kind == sdrm_pkg::KIND_FLOOR_MOD)
        begin
            if (sg_ctl_reg.div_zero)
            begin
                out_ans_next = '0;
                out_err_next = sdrm_pkg::ERR_DIV_ZERO;
            end
            else if (sg_ctl_reg.ovf
                     && (sg_ctl_reg.kind == sdrm_pkg::KIND_EUCLID_QUO
                         || sg_ctl_reg.kind == sdrm_pkg::KIND_TRUNC_QUO))
            begin
                out_err_next = sdrm_pkg::ERR_OVERFLOW;
            end
        end
    end

    always_comb
    begin
        if (out_ready)
        begin
            out_valid_next = sg_valid_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ans_reg <= out_ans_next;
            out_err_reg <= out_err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_BITS'(out_ans_reg);
    assign m_axis_tuser  = out_err_reg;

endmodule

`default_nettype wire
